@@ hw/rtl/sc2a_pkg.sv @@
// ----------------------------------------------------------------------------
// sc2a_pkg
// Scan code set-1 constants, result type and the character lookup functions.
// ----------------------------------------------------------------------------
package sc2a_pkg;

  localparam int unsigned FKEY_COUNT = 10;
  localparam int unsigned FKEY_IDX_W = 4;
  localparam int unsigned LED_W      = 3;

  localparam logic [7:0] SC_PREFIX     = 8'hE0;
  localparam logic [7:0] SC_LSHIFT     = 8'h2A;
  localparam logic [7:0] SC_RSHIFT     = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
  localparam logic [7:0] SC_CTRL       = 8'h1D;
  localparam logic [7:0] SC_CTRL_BRK   = 8'h9D;
  localparam logic [7:0] SC_ALT        = 8'h38;
  localparam logic [7:0] SC_ALT_BRK    = 8'hB8;
  localparam logic [7:0] SC_CAPS       = 8'h3A;
  localparam logic [7:0] SC_NUM        = 8'h45;
  localparam logic [7:0] SC_SCROLL     = 8'h46;
  localparam logic [7:0] SC_F1         = 8'h3B;
  localparam logic [7:0] SC_F10        = 8'h44;
  localparam logic [7:0] SC_ARM_LO     = 8'hBA;
  localparam logic [7:0] SC_ARM_HI     = 8'hC6;
  localparam logic [6:0] SC_BACKSLASH  = 7'h2B;

  localparam logic [7:0] CH_NONPRINT   = 8'h80;
  localparam logic [7:0] CH_CASE_BIT   = 8'h20;

  typedef struct packed {
    logic                  char_valid;
    logic [7:0]            ascii_char;
    logic                  fkey_valid;
    logic [FKEY_IDX_W-1:0] fkey_index;
    logic                  led_send;
    logic [LED_W-1:0]      led_mask;
    logic                  shift_down;
    logic                  ctrl_down;
    logic                  alt_down;
  } result_t;

  function automatic logic [7:0] plain_char(input logic [6:0] code);
    logic [7:0] c;
    unique case (code)
      7'h00: c = 8'h00;
      7'h01: c = 8'h1B;
      7'h02: c = "1";
      7'h03: c = "2";
      7'h04: c = "3";
      7'h05: c = "4";
      7'h06: c = "5";
      7'h07: c = "6";
      7'h08: c = "7";
      7'h09: c = "8";
      7'h0A: c = "9";
      7'h0B: c = "0";
      7'h0C: c = "-";
      7'h0D: c = "=";
      7'h0E: c = 8'h08;
      7'h0F: c = 8'h09;
      7'h10: c = "q";
      7'h11: c = "w";
      7'h12: c = "e";
      7'h13: c = "r";
      7'h14: c = "t";
      7'h15: c = "y";
      7'h16: c = "u";
      7'h17: c = "i";
      7'h18: c = "o";
      7'h19: c = "p";
      7'h1A: c = "[";
      7'h1B: c = "]";
      7'h1C: c = 8'h0D;
      7'h1E: c = "a";
      7'h1F: c = "s";
      7'h20: c = "d";
      7'h21: c = "f";
      7'h22: c = "g";
      7'h23: c = "h";
      7'h24: c = "j";
      7'h25: c = "k";
      7'h26: c = "l";
      7'h27: c = ";";
      7'h28: c = 8'h27;
      7'h29: c = 8'h60;
      7'h2B: c = 8'h5C;
      7'h2C: c = "z";
      7'h2D: c = "x";
      7'h2E: c = "c";
      7'h2F: c = "v";
      7'h30: c = "b";
      7'h31: c = "n";
      7'h32: c = "m";
      7'h33: c = ",";
      7'h34: c = ".";
      7'h35: c = "/";
      7'h37: c = "*";
      7'h39: c = " ";
      7'h44: c = 8'h0A;
      7'h4A: c = "-";
      7'h4E: c = "+";
      7'h53: c = 8'h7F;
      default: c = CH_NONPRINT;
    endcase
    return c;
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= "a") && (c <= "z");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return is_lower(c) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic [7:0] shifted_char(input logic [6:0] code);
    logic [7:0] base;
    logic [7:0] c;
    base = plain_char(code);
    unique case (code)
      7'h02: c = "!";
      7'h03: c = "@";
      7'h04: c = "#";
      7'h05: c = "$";
      7'h06: c = "%";
      7'h07: c = "^";
      7'h08: c = "&";
      7'h09: c = "*";
      7'h0A: c = "(";
      7'h0B: c = ")";
      7'h0C: c = "_";
      7'h0D: c = "+";
      7'h1A: c = "{";
      7'h1B: c = "}";
      7'h27: c = ":";
      7'h28: c = 8'h22;
      7'h29: c = "~";
      7'h2B: c = "|";
      7'h33: c = "<";
      7'h34: c = ">";
      7'h35: c = "?";
      7'h47: c = "7";
      7'h48: c = "8";
      7'h49: c = "9";
      7'h4B: c = "4";
      7'h4C: c = "5";
      7'h4D: c = "6";
      7'h4F: c = "1";
      7'h50: c = "2";
      7'h51: c = "3";
      7'h52: c = "0";
      default: c = is_lower(base) ? (base ^ CH_CASE_BIT) : base;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] keypad_char(input logic [6:0] code, input logic [7:0] fallback);
    logic [7:0] c;
    unique case (code)
      7'h47: c = "7";
      7'h48: c = "8";
      7'h49: c = "9";
      7'h4B: c = "4";
      7'h4C: c = "5";
      7'h4D: c = "6";
      7'h4F: c = "1";
      7'h50: c = "2";
      7'h51: c = "3";
      7'h52: c = "0";
      7'h53: c = ".";
      default: c = fallback;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] key_char(input logic [6:0] code, input logic shift,
                                          input logic caps, input logic num);
    logic [7:0] c;
    c = shift ? shifted_char(code) : plain_char(code);
    if (caps && (is_letter(c) || (code == SC_BACKSLASH))) begin
      c = c ^ CH_CASE_BIT;
    end
    if (num) begin
      c = keypad_char(code, c);
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/sc2a_kbd_state.sv @@
// ----------------------------------------------------------------------------
// sc2a_kbd_state
// Modifier and lock state with the per-code decode into one result.
// ----------------------------------------------------------------------------
module sc2a_kbd_state import sc2a_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            code,
  input  logic [FKEY_COUNT-1:0] fkey_mask,
  output result_t               res
);

  logic shift_held, ctrl_held, alt_held;
  logic caps_on, num_on, scroll_on, armed;
  logic shift_held_next, ctrl_held_next, alt_held_next;
  logic caps_on_next, num_on_next, scroll_on_next, armed_next;
  logic [FKEY_IDX_W-1:0] fidx;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= 1'b0;
      ctrl_held  <= 1'b0;
      alt_held   <= 1'b0;
      caps_on    <= 1'b0;
      num_on     <= 1'b0;
      scroll_on  <= 1'b0;
      armed      <= 1'b1;
    end else if (step) begin
      shift_held <= shift_held_next;
      ctrl_held  <= ctrl_held_next;
      alt_held   <= alt_held_next;
      caps_on    <= caps_on_next;
      num_on     <= num_on_next;
      scroll_on  <= scroll_on_next;
      armed      <= armed_next;
    end
  end

  assign fidx = FKEY_IDX_W'(code - SC_F1);

  always_comb begin
    shift_held_next = shift_held;
    ctrl_held_next  = ctrl_held;
    alt_held_next   = alt_held;
    caps_on_next    = caps_on;
    num_on_next     = num_on;
    scroll_on_next  = scroll_on;
    armed_next      = armed;
    res             = '0;
    unique case (code)
      SC_LSHIFT, SC_RSHIFT:         shift_held_next = 1'b1;
      SC_LSHIFT_BRK, SC_RSHIFT_BRK: shift_held_next = 1'b0;
      SC_CTRL:                      ctrl_held_next  = 1'b1;
      SC_CTRL_BRK:                  ctrl_held_next  = 1'b0;
      SC_ALT:                       alt_held_next   = 1'b1;
      SC_ALT_BRK:                   alt_held_next   = 1'b0;
      SC_CAPS: begin
        if (armed) begin
          caps_on_next = !caps_on;
          res.led_send = 1'b1;
          armed_next   = 1'b0;
        end
      end
      SC_NUM: begin
        if (armed) begin
          num_on_next  = !num_on;
          res.led_send = 1'b1;
          armed_next   = 1'b0;
        end
      end
      SC_SCROLL: begin
        if (armed) begin
          scroll_on_next = !scroll_on;
          res.led_send   = 1'b1;
          armed_next     = 1'b0;
        end
      end
      SC_PREFIX: ;
      default: begin
        if ((code >= SC_F1) && (code <= SC_F10)) begin
          if (armed && fkey_mask[fidx]) begin
            res.fkey_valid = 1'b1;
            res.fkey_index = fidx;
            armed_next     = 1'b0;
          end
        end else if ((code >= SC_ARM_LO) && (code <= SC_ARM_HI)) begin
          armed_next = 1'b1;
        end else if (!code[7]) begin
          res.char_valid = 1'b1;
          res.ascii_char = key_char(code[6:0], shift_held, caps_on, num_on);
        end
      end
    endcase
    res.led_mask   = {caps_on_next, num_on_next, scroll_on_next};
    res.shift_down = shift_held_next;
    res.ctrl_down  = ctrl_held_next;
    res.alt_down   = alt_held_next;
  end

endmodule

@@ hw/rtl/sc2a_out_reg.sv @@
// ----------------------------------------------------------------------------
// sc2a_out_reg
// Result register; takes a new result whenever empty or being drained.
// ----------------------------------------------------------------------------
module sc2a_out_reg import sc2a_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res_in,
  output logic    take,
  output logic    valid,
  input  logic    ready,
  output result_t res
);

  assign take = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (take && load) begin
      res <= res_in;
    end
  end

endmodule

@@ hw/rtl/scan_code_to_ascii_decoder.sv @@
// ----------------------------------------------------------------------------
// scan_code_to_ascii_decoder
// Set-1 keyboard scan code to ASCII, modifier, lock LED and function key decode.
// ----------------------------------------------------------------------------
// Channels: scan codes enter on in_valid/in_ready with scan_code; every code
// gives exactly one result on out_valid/out_ready carrying character,
// function key, LED request and modifier fields. fkey_enable_mask is written
// on cfg_valid/cfg_ready, which is always ready; write it only while idle.
// Path: an accepted code is registered at the input, decoded against the
// modifier/lock state, and registered again in the result register that
// drives out_valid.
// Throughput: one code per cycle while out_ready stays high; the decode is one
// lookup plus flag update between the input register and the result register.
// Reset: clears both registers' valid flags, all modifiers and locks, arms
// the lock keys and clears the function key enable mask.
// Stall: while out_ready is low the result holds; an empty input register still
// takes one more request, after which in_ready drops until the result drains.
// ----------------------------------------------------------------------------
module scan_code_to_ascii_decoder import sc2a_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            scan_code,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [FKEY_COUNT-1:0] fkey_enable_mask,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  char_valid,
  output logic [7:0]            ascii_char,
  output logic                  fkey_valid,
  output logic [FKEY_IDX_W-1:0] fkey_index,
  output logic                  led_send,
  output logic [LED_W-1:0]      led_mask,
  output logic                  shift_down,
  output logic                  ctrl_down,
  output logic                  alt_down
);

  logic                  code_valid;
  logic [7:0]            code;
  logic [FKEY_COUNT-1:0] fkey_mask;
  logic                  take;
  logic                  step;
  result_t               dec_res;
  result_t               out_res;

  assign cfg_ready = 1'b1;
  assign step      = code_valid && take;
  assign in_ready  = !code_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      fkey_mask <= '0;
    end else if (cfg_valid && cfg_ready) begin
      fkey_mask <= fkey_enable_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else if (in_ready) begin
      code_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      code <= scan_code;
    end
  end

  sc2a_kbd_state u_state (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .code      (code),
    .fkey_mask (fkey_mask),
    .res       (dec_res)
  );

  sc2a_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (code_valid),
    .res_in (dec_res),
    .take   (take),
    .valid  (out_valid),
    .ready  (out_ready),
    .res    (out_res)
  );

  assign char_valid = out_res.char_valid;
  assign ascii_char = out_res.ascii_char;
  assign fkey_valid = out_res.fkey_valid;
  assign fkey_index = out_res.fkey_index;
  assign led_send   = out_res.led_send;
  assign led_mask   = out_res.led_mask;
  assign shift_down = out_res.shift_down;
  assign ctrl_down  = out_res.ctrl_down;
  assign alt_down   = out_res.alt_down;

endmodule

@@ hw/rtl/sc2a_checker.sv @@
// ----------------------------------------------------------------------------
// sc2a_checker
// Port-level checks for the scan code decoder, bound to the top level.
// ----------------------------------------------------------------------------
module sc2a_checker import sc2a_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  char_valid,
  input logic [7:0]            ascii_char,
  input logic                  fkey_valid,
  input logic [FKEY_IDX_W-1:0] fkey_index,
  input logic                  led_send
);

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_one_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && char_valid |-> !fkey_valid && !led_send)
    else $error("character together with key or LED event");

  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !char_valid |-> ascii_char == 8'h00)
    else $error("character byte set without character");

  a_fkey_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && fkey_valid |-> fkey_index < FKEY_IDX_W'(FKEY_COUNT))
    else $error("function key index out of range");

endmodule

bind scan_code_to_ascii_decoder sc2a_checker u_sc2a_checker (.*);

@@ tb/sv/scan_code_to_ascii_decoder_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scan_code_to_ascii_decoder_tb
// Drives set-1 scan codes through the decoder and checks every result against
// a local decode of the modifier, lock, function key and character tables.
// A short directed list comes first, then random keystroke sequences under
// several fkey enable masks, random idle bursts on both sides but in the last.
// ----------------------------------------------------------------------------
module scan_code_to_ascii_decoder_tb;
  import sc2a_pkg::*;

  localparam int TABLE_CODES    = 84;
  localparam int PHASE_ITEMS    = 205;
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            scan_code = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [FKEY_COUNT-1:0] fkey_enable_mask = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  char_valid;
  logic [7:0]            ascii_char;
  logic                  fkey_valid;
  logic [FKEY_IDX_W-1:0] fkey_index;
  logic                  led_send;
  logic [LED_W-1:0]      led_mask;
  logic                  shift_down;
  logic                  ctrl_down;
  logic                  alt_down;

  logic [7:0]            scan_backlog[$];
  result_t               decoded_q[$];
  int                    fault_count = 0;
  int                    stall_cycles = 0;
  int                    in_gap = 0;
  int                    out_gap = 0;
  logic                  steady_flow = 1'b0;

  logic [7:0]            char_lut[0:3][0:TABLE_CODES-1];
  string                 numpad_keys = "789-456+1230.";

  logic [FKEY_COUNT-1:0] fkey_mask_q;
  logic                  kb_shift, kb_ctrl, kb_alt;
  logic                  kb_caps, kb_num, kb_scroll, kb_armed;

  scan_code_to_ascii_decoder u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .scan_code        (scan_code),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .fkey_enable_mask (fkey_enable_mask),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .char_valid       (char_valid),
    .ascii_char       (ascii_char),
    .fkey_valid       (fkey_valid),
    .fkey_index       (fkey_index),
    .led_send         (led_send),
    .led_mask         (led_mask),
    .shift_down       (shift_down),
    .ctrl_down        (ctrl_down),
    .alt_down         (alt_down)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void put_row(input int sel, input int first, input string s);
    for (int i = 0; i < s.len(); i++) begin
      char_lut[sel][first + i] = s[i];
    end
  endfunction

  function automatic result_t decode_scan_code(input logic [7:0] code);
    result_t    r;
    logic       typed;
    logic [3:0] fk;
    logic [7:0] c;
    r = '0;
    typed = 1'b0;
    case (code)
      SC_LSHIFT, SC_RSHIFT: kb_shift = 1'b1;
      SC_LSHIFT_BRK, SC_RSHIFT_BRK: kb_shift = 1'b0;
      SC_CTRL: kb_ctrl = 1'b1;
      SC_CTRL_BRK: kb_ctrl = 1'b0;
      SC_ALT: kb_alt = 1'b1;
      SC_ALT_BRK: kb_alt = 1'b0;
      SC_CAPS, SC_NUM, SC_SCROLL: begin
        if (kb_armed) begin
          if (code == SC_CAPS) kb_caps = !kb_caps;
          else if (code == SC_NUM) kb_num = !kb_num;
          else kb_scroll = !kb_scroll;
          r.led_send = 1'b1;
          kb_armed = 1'b0;
        end
      end
      SC_PREFIX: ;
      default: begin
        if (code >= SC_F1 && code <= SC_F10) begin
          fk = 4'(code - SC_F1);
          if (kb_armed && fkey_mask_q[fk]) begin
            r.fkey_valid = 1'b1;
            r.fkey_index = fk;
            kb_armed = 1'b0;
          end
        end else if (code >= SC_ARM_LO && code <= SC_ARM_HI) begin
          kb_armed = 1'b1;
        end else if (!code[7]) begin
          typed = 1'b1;
        end
      end
    endcase
    if (typed) begin
      c = (code < TABLE_CODES) ? char_lut[{kb_shift, kb_caps}][code[6:0]] : CH_NONPRINT;
      if (kb_num && code >= 8'h47 && code <= 8'h53) c = numpad_keys[code - 8'h47];
      r.char_valid = 1'b1;
      r.ascii_char = c;
    end
    r.led_mask   = {kb_caps, kb_num, kb_scroll};
    r.shift_down = kb_shift;
    r.ctrl_down  = kb_ctrl;
    r.alt_down   = kb_alt;
    return r;
  endfunction

  function automatic void add_keystroke();
    logic [7:0] k;
    logic [7:0] m;
    int         pick;
    pick = $urandom_range(0, 99);
    k = 8'($urandom_range(0, 127));
    m = ($urandom_range(0, 1) == 1) ? SC_RSHIFT : SC_LSHIFT;
    if (pick < 40) begin
      scan_backlog.push_back(k);
      scan_backlog.push_back(k | 8'h80);
    end else if (pick < 55) begin
      scan_backlog.push_back(m);
      scan_backlog.push_back(k);
      scan_backlog.push_back(k | 8'h80);
      scan_backlog.push_back(m | 8'h80);
    end else if (pick < 65) begin
      case ($urandom_range(0, 2))
        0: m = SC_CAPS;
        1: m = SC_NUM;
        default: m = SC_SCROLL;
      endcase
      scan_backlog.push_back(m);
      scan_backlog.push_back(m | 8'h80);
    end else if (pick < 75) begin
      m = SC_F1 + 8'($urandom_range(0, FKEY_COUNT - 1));
      scan_backlog.push_back(m);
      scan_backlog.push_back(m | 8'h80);
    end else if (pick < 83) begin
      m = ($urandom_range(0, 1) == 1) ? SC_ALT : SC_CTRL;
      scan_backlog.push_back(m);
      scan_backlog.push_back(k);
      scan_backlog.push_back(k | 8'h80);
      scan_backlog.push_back(m | 8'h80);
    end else if (pick < 90) begin
      scan_backlog.push_back(SC_PREFIX);
      scan_backlog.push_back(k);
      scan_backlog.push_back(SC_PREFIX);
      scan_backlog.push_back(k | 8'h80);
    end else begin
      scan_backlog.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fault_count++;
    end
  endfunction

  task automatic program_mask(input logic [FKEY_COUNT-1:0] value);
    @(posedge clk);
    cfg_valid        <= 1'b1;
    fkey_enable_mask <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    fkey_mask_q = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic settle(input int extra);
    while (scan_backlog.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  always @(posedge clk) begin : feed_scan_codes
    if (rst) begin
      in_valid    <= 1'b0;
      in_gap      = 0;
      fkey_mask_q = '0;
      kb_shift    = 1'b0;
      kb_ctrl     = 1'b0;
      kb_alt      = 1'b0;
      kb_caps     = 1'b0;
      kb_num      = 1'b0;
      kb_scroll   = 1'b0;
      kb_armed    = 1'b1;
    end else begin
      if (in_valid && in_ready) decoded_q.push_back(decode_scan_code(scan_code));
      if (in_valid && !in_ready) begin
        // hold the request
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (scan_backlog.size() != 0 && !steady_flow && $urandom_range(0, 3) == 0) begin
        in_gap = $urandom_range(0, 5);
        in_valid <= 1'b0;
      end else if (scan_backlog.size() != 0) begin
        in_valid  <= 1'b1;
        scan_code <= scan_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $error("result with no pending request: ascii_char %0h", ascii_char);
          fault_count++;
        end else begin
          want = decoded_q.pop_front();
          check_field("char_valid", 8'(want.char_valid), 8'(char_valid));
          check_field("ascii_char", want.ascii_char, ascii_char);
          check_field("fkey_valid", 8'(want.fkey_valid), 8'(fkey_valid));
          check_field("fkey_index", 8'(want.fkey_index), 8'(fkey_index));
          check_field("led_send", 8'(want.led_send), 8'(led_send));
          check_field("led_mask", 8'(want.led_mask), 8'(led_mask));
          check_field("shift_down", 8'(want.shift_down), 8'(shift_down));
          check_field("ctrl_down", 8'(want.ctrl_down), 8'(ctrl_down));
          check_field("alt_down", 8'(want.alt_down), 8'(alt_down));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (!steady_flow && $urandom_range(0, 4) == 0) begin
        out_gap = $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : run_sequence
    logic [7:0] c;
    for (int s = 0; s < 4; s += 2) begin
      for (int k = 0; k < TABLE_CODES; k++) char_lut[s][k] = CH_NONPRINT;
      char_lut[s][8'h00] = 8'h00;
      char_lut[s][8'h01] = 8'h1B;
      char_lut[s][8'h0E] = 8'h08;
      char_lut[s][8'h0F] = 8'h09;
      char_lut[s][8'h1C] = 8'h0D;
      char_lut[s][8'h37] = "*";
      char_lut[s][8'h39] = " ";
      char_lut[s][8'h44] = 8'h0A;
      char_lut[s][8'h4A] = "-";
      char_lut[s][8'h4E] = "+";
      char_lut[s][8'h53] = 8'h7F;
    end
    put_row(0, 8'h02, "1234567890-=");
    put_row(0, 8'h10, "qwertyuiop[]");
    put_row(0, 8'h1E, "asdfghjkl;'");
    char_lut[0][8'h29] = 8'h60;
    put_row(0, 8'h2B, "\\zxcvbnm,./");
    put_row(2, 8'h02, "!@#$%^&*()_+");
    put_row(2, 8'h10, "QWERTYUIOP{}");
    put_row(2, 8'h1E, "ASDFGHJKL:\"~");
    put_row(2, 8'h2B, "|ZXCVBNM<>?");
    put_row(2, 8'h47, "789-456+1230");
    // caps flips letter case and the backslash/bar key
    for (int k = 0; k < TABLE_CODES; k++) begin
      for (int s = 0; s < 4; s += 2) begin
        c = char_lut[s][k];
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || k == SC_BACKSLASH)
          c = c ^ CH_CASE_BIT;
        char_lut[s + 1][k] = c;
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    program_mask(10'h3FF);

    @(negedge clk);
    scan_backlog = '{8'h00, 8'hFF, 8'h54, 8'h7F, SC_LSHIFT, 8'h0B, 8'h2B, SC_LSHIFT_BRK,
                     SC_CAPS, SC_NUM, SC_ARM_LO, 8'h1E, SC_NUM, 8'h47, 8'h4E, 8'h53,
                     SC_ARM_HI, SC_F1, SC_F10, 8'hC0, SC_F10, SC_PREFIX, SC_CTRL, SC_ALT,
                     SC_SCROLL};

    for (int phase = 0; phase < 5; phase++) begin
      settle(4);
      case (phase)
        0: program_mask(10'h000);
        1: program_mask(10'h155);
        2: program_mask(10'h2AA);
        3: program_mask(10'($urandom_range(0, 1023)));
        default: program_mask(10'h3FF);
      endcase
      @(negedge clk);
      if (phase == 4) steady_flow = 1'b1;
      while (scan_backlog.size() < PHASE_ITEMS) add_keystroke();
    end

    settle(TAIL_CYCLES);
    if (fault_count == 0 && decoded_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
